>>> src/deadline_request_scheduler_macros.svh
// Assertion macros for the deadline request scheduler.
`ifndef DEADLINE_REQUEST_SCHEDULER_MACROS_SVH
`define DEADLINE_REQUEST_SCHEDULER_MACROS_SVH
`ifndef SYNTH
`define DSCH_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scheduler check failed");
`define DSCH_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scheduler check failed");
`else
`define DSCH_ASSERT_IMPL(label, clk, rst, ante, cons)
`define DSCH_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> src/dsch_pkg.sv
package dsch_pkg;

  localparam int DEPTH = 64;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int SEC_W = 48;
  localparam int ID_W = 16;

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_DISPATCH = 2'd1;
  localparam logic [1:0] CMD_COMPLETE = 2'd2;
  localparam logic [1:0] CMD_MERGE = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_MISS = 2'd3;

  localparam logic [2:0] REG_READ_EXPIRE = 3'd0;
  localparam logic [2:0] REG_WRITE_EXPIRE = 3'd1;
  localparam logic [2:0] REG_STARVED_LIMIT = 3'd2;
  localparam logic [2:0] REG_BATCH_LIMIT = 3'd3;
  localparam logic [2:0] REG_FRONT_MERGE = 3'd4;
  localparam logic [2:0] REG_THINKTIME = 3'd5;
  localparam logic [2:0] REG_LAT_TARGET = 3'd6;
  localparam logic [2:0] REG_LAT_WINDOW = 3'd7;

  typedef struct packed {
    logic dir;
    logic [SEC_W-1:0] sector;
    logic [ID_W-1:0] id;
    logic [31:0] deadline;
    logic [31:0] order;
  } ent_t;

  typedef struct packed {
    logic older_cb;
    logic before_cb;
    logic before_rc;
  } cmp_t;

endpackage

>>> src/dsch_req_if.sv
interface dsch_req_if;
  logic valid;
  logic ready;
  logic [1:0] cmd;
  logic dir;
  logic [dsch_pkg::SEC_W-1:0] sector;
  logic [15:0] length;
  logic [dsch_pkg::ID_W-1:0] req_id;
  logic [31:0] now;
  logic [31:0] latency;
  logic passthrough;
  logic merge_ok;
  modport source(output valid, cmd, dir, sector, length, req_id, now, latency, passthrough,
                 merge_ok, input ready);
  modport sink(input valid, cmd, dir, sector, length, req_id, now, latency, passthrough,
               merge_ok, output ready);
endinterface

>>> src/dsch_rsp_if.sv
interface dsch_rsp_if;
  logic valid;
  logic ready;
  logic [1:0] status;
  logic [dsch_pkg::ID_W-1:0] out_id;
  logic out_dir;
  logic [dsch_pkg::SEC_W-1:0] out_sector;
  logic tight_flag;
  logic [31:0] latency_average;
  modport source(output valid, status, out_id, out_dir, out_sector, tight_flag,
                 latency_average, input ready);
  modport sink(input valid, status, out_id, out_dir, out_sector, tight_flag,
               latency_average, output ready);
endinterface

>>> src/dsch_cfg_if.sv
interface dsch_cfg_if;
  logic valid;
  logic ready;
  logic [2:0] addr;
  logic [31:0] data;
  modport source(output valid, addr, data, input ready);
  modport sink(input valid, addr, data, output ready);
endinterface

>>> src/dsch_store.sv
module dsch_store (
  input  logic clk,
  input  logic rd_en,
  input  logic [dsch_pkg::IDX_W-1:0] rd_addr,
  output dsch_pkg::ent_t rd_data,
  input  logic we,
  input  logic [dsch_pkg::IDX_W-1:0] wr_addr,
  input  dsch_pkg::ent_t wr_data
);

  dsch_pkg::ent_t mem [dsch_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> src/dsch_cmp.sv
module dsch_cmp (
  input  logic [31:0] ctr,
  input  logic [dsch_pkg::SEC_W-1:0] cand_sector,
  input  logic [31:0] cand_order,
  input  logic [dsch_pkg::SEC_W-1:0] best_sector,
  input  logic [31:0] best_order,
  input  logic [dsch_pkg::SEC_W-1:0] ref_sector,
  input  logic [31:0] ref_order,
  output dsch_pkg::cmp_t res
);

  // Age is measured back from the arrival counter so that order wraps cleanly.
  logic [31:0] age_c, age_b, age_r;

  always_comb begin
    age_c = ctr - cand_order;
    age_b = ctr - best_order;
    age_r = ctr - ref_order;
    res.older_cb = age_c > age_b;
    res.before_cb = (cand_sector != best_sector) ? (cand_sector < best_sector)
                                                 : (age_c > age_b);
    res.before_rc = (ref_sector != cand_sector) ? (ref_sector < cand_sector)
                                                : (age_r > age_c);
  end

endmodule

>>> src/deadline_request_scheduler.sv
// Channel  Modport  Contents
// req      sink     cmd, dir, sector, length, req_id, now, latency, passthrough, merge_ok
// rsp      source   status, out_id, out_dir, out_sector, tight_flag, latency_average
// cfg      sink     addr (register index), data
// An add or a front merge makes one sweep over the 64-entry table memory and a dispatch
// two, one entry per cycle; a complete makes no sweep. The table memory has one read
// port that the sweeps use.
// rst is synchronous and clears the valid bits and all control state.
// A finished result waits in the output register; a new item may be taken meanwhile.
// Configuration writes are always taken.
`include "deadline_request_scheduler_macros.svh"

module deadline_request_scheduler (
  input logic clk,
  input logic rst,
  dsch_req_if.sink req,
  dsch_rsp_if.source rsp,
  dsch_cfg_if.sink cfg
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_DECIDE = 5'b00100,
    S_LATTER = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic dir;
    logic [dsch_pkg::SEC_W-1:0] sector;
    logic [dsch_pkg::SEC_W-1:0] key;
    logic [dsch_pkg::ID_W-1:0] req_id;
    logic [31:0] now;
    logic merge_ok;
  } item_t;

  state_t state;
  item_t q;

  logic [15:0] rd_expiry, wr_expiry;
  logic [7:0] starved_limit, batch_limit, thinktime, lat_window;
  logic front_merge;
  logic [31:0] lat_target;

  logic [dsch_pkg::DEPTH-1:0] valid;
  logic [31:0] arrival;
  logic [1:0] n_ok;
  logic [dsch_pkg::IDX_W-1:0] n_idx [2];
  dsch_pkg::ent_t n_ent [2];
  logic [7:0] batch_count, starve_count;
  logic [31:0] prev_pick_time;
  logic think_flag;
  logic [31:0] ema, window_max;
  logic [7:0] window_count;
  logic tight;

  logic [dsch_pkg::IDX_W:0] cnt;
  logic pv;
  logic [dsch_pkg::IDX_W-1:0] pidx;
  logic scan_end;

  dsch_pkg::ent_t rh, wh, hit, rsel, lat;
  logic [dsch_pkg::IDX_W-1:0] rh_idx, wh_idx, hit_idx, r_idx, lat_idx, free_idx;
  logic rh_ok, wh_ok, hit_ok, lat_ok, free_ok;

  logic [1:0] res_status;
  logic [dsch_pkg::ID_W-1:0] res_id;
  logic res_dir;
  logic [dsch_pkg::SEC_W-1:0] res_sector;

  dsch_pkg::ent_t rd_data, wr_data;
  logic we;
  logic [dsch_pkg::IDX_W-1:0] wr_addr;
  logic rd_en;

  dsch_pkg::ent_t best;
  dsch_pkg::cmp_t cmp;
  logic cand_v;

  dsch_store u_store (
    .clk(clk), .rd_en(rd_en), .rd_addr(cnt[dsch_pkg::IDX_W-1:0]), .rd_data(rd_data),
    .we(we), .wr_addr(wr_addr), .wr_data(wr_data)
  );

  dsch_cmp u_cmp (
    .ctr(arrival), .cand_sector(rd_data.sector), .cand_order(rd_data.order),
    .best_sector(best.sector), .best_order(best.order),
    .ref_sector(rsel.sector), .ref_order(rsel.order), .res(cmp)
  );

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign rd_en = (state == S_SCAN || state == S_LATTER) &&
                 (cnt < (dsch_pkg::IDX_W+1)'(dsch_pkg::DEPTH));
  assign scan_end = (cnt == (dsch_pkg::IDX_W+1)'(dsch_pkg::DEPTH)) && !pv;
  assign cand_v = pv && valid[pidx];

  always_comb begin
    case (q.cmd)
      dsch_pkg::CMD_MERGE: best = hit;
      dsch_pkg::CMD_DISPATCH: best = (state == S_LATTER) ? lat : (rd_data.dir ? wh : rh);
      default: best = rh;
    endcase
  end

  // Table writes: an add stores a new entry, a front merge rewrites the start.
  always_comb begin
    we = 1'b0;
    wr_addr = free_idx;
    wr_data = hit;
    wr_data.sector = q.sector;
    if (state == S_SCAN && scan_end) begin
      if (q.cmd == dsch_pkg::CMD_ADD && free_ok) begin
        we = 1'b1;
        wr_data.dir = q.dir;
        wr_data.sector = q.sector;
        wr_data.id = q.req_id;
        wr_data.deadline = q.now + (q.dir ? {16'd0, wr_expiry} : {16'd0, rd_expiry});
        wr_data.order = arrival;
      end else if (q.cmd == dsch_pkg::CMD_MERGE && front_merge && hit_ok && q.merge_ok) begin
        we = 1'b1;
        wr_addr = hit_idx;
      end
    end
  end

  // Direction decision and pick for a dispatch.
  logic live_n0, live_n1;
  logic [7:0] bc1, d_bc, d_st, st_inc;
  logic [31:0] idle_diff, dl_diff;
  logic idle_hit, think1, d_th, ddir, live_nd;
  logic [7:0] st1;
  dsch_pkg::ent_t d_r, head;
  logic [dsch_pkg::IDX_W-1:0] d_idx, head_idx;

  always_comb begin
    live_n0 = n_ok[0] && valid[n_idx[0]];
    live_n1 = n_ok[1] && valid[n_idx[1]];
    bc1 = (tight && batch_count != 8'd0) ? batch_limit : batch_count;
    idle_diff = prev_pick_time + {24'd0, thinktime} - q.now;
    idle_hit = (prev_pick_time != 32'd0) && idle_diff[31];
    think1 = idle_hit ? 1'b1 : think_flag;
    st1 = idle_hit ? 8'd0 : starve_count;
    st_inc = (st1 == 8'd255) ? st1 : st1 + 8'd1;
    d_th = think1;
    d_st = st1;
    ddir = 1'b0;
    if (!rh_ok) begin
      d_st = 8'd0;
      ddir = 1'b1;
    end else if (think1) begin
      d_th = 1'b0;
    end else if (st1 < starved_limit || !wh_ok) begin
      d_th = 1'b0;
      d_st = st_inc;
    end else begin
      d_st = 8'd0;
      ddir = 1'b1;
    end
    head = ddir ? wh : rh;
    head_idx = ddir ? wh_idx : rh_idx;
    live_nd = ddir ? live_n1 : live_n0;
    dl_diff = head.deadline - 32'd1 - q.now;
    if (dl_diff[31] || !live_nd) begin
      d_r = head;
      d_idx = head_idx;
    end else begin
      d_r = n_ent[ddir];
      d_idx = n_idx[ddir];
    end
    d_bc = 8'd1;
    if ((live_n0 || live_n1) && bc1 < batch_limit) begin
      d_r = live_n1 ? n_ent[1] : n_ent[0];
      d_idx = live_n1 ? n_idx[1] : n_idx[0];
      d_bc = bc1 + 8'd1;
      d_th = think1;
      d_st = st1;
    end
  end

  // Completion: moving average and windowed tight mode.
  logic [31:0] ema_next, wmax_next;
  logic [7:0] wc_next;
  logic [32:0] down_step;

  always_comb begin
    down_step = {1'b0, ema - req.latency} + 33'd7;
    if (ema == 32'd0) begin
      ema_next = req.latency;
    end else if (req.latency >= ema) begin
      ema_next = ema + ((req.latency - ema) >> 3);
    end else begin
      ema_next = ema - 32'(down_step >> 3);
    end
    wmax_next = (req.latency > window_max) ? req.latency : window_max;
    wc_next = window_count + 8'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rd_expiry <= 16'd6;
      wr_expiry <= 16'd30;
      starved_limit <= 8'd6;
      batch_limit <= 8'd6;
      front_merge <= 1'b1;
      thinktime <= 8'd2;
      lat_target <= 32'd5000000;
      lat_window <= 8'd4;
      valid <= '0;
      arrival <= '0;
      n_ok <= '0;
      batch_count <= '0;
      starve_count <= '0;
      prev_pick_time <= '0;
      think_flag <= 1'b0;
      ema <= '0;
      window_max <= '0;
      window_count <= '0;
      tight <= 1'b0;
      rsp.valid <= 1'b0;
      cnt <= '0;
      pv <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.addr)
          dsch_pkg::REG_READ_EXPIRE: rd_expiry <= cfg.data[15:0];
          dsch_pkg::REG_WRITE_EXPIRE: wr_expiry <= cfg.data[15:0];
          dsch_pkg::REG_STARVED_LIMIT: starved_limit <= cfg.data[7:0];
          dsch_pkg::REG_BATCH_LIMIT: batch_limit <= cfg.data[7:0];
          dsch_pkg::REG_FRONT_MERGE: front_merge <= cfg.data[0];
          dsch_pkg::REG_THINKTIME: thinktime <= cfg.data[7:0];
          dsch_pkg::REG_LAT_TARGET: lat_target <= cfg.data;
          dsch_pkg::REG_LAT_WINDOW: lat_window <= cfg.data[7:0];
          default: ;
        endcase
      end
      if (rsp.valid && rsp.ready && state != S_DONE) begin
        rsp.valid <= 1'b0;
      end

      pv <= rd_en;
      if (rd_en) begin
        cnt <= cnt + (dsch_pkg::IDX_W+1)'(1);
      end

      case (state)
        S_IDLE: begin
          if (req.valid) begin
            cnt <= '0;
            if (req.cmd == dsch_pkg::CMD_COMPLETE) begin
              if (!req.dir && !req.passthrough) begin
                ema <= ema_next;
                if (wc_next >= lat_window) begin
                  tight <= wmax_next > lat_target;
                  window_max <= '0;
                  window_count <= '0;
                end else begin
                  window_max <= wmax_next;
                  window_count <= wc_next;
                end
              end
              state <= S_DONE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (scan_end) begin
            state <= S_DONE;
            if (q.cmd == dsch_pkg::CMD_ADD && free_ok) begin
              valid[free_idx] <= 1'b1;
              arrival <= arrival + 32'd1;
            end
            if (q.cmd == dsch_pkg::CMD_DISPATCH && (rh_ok || wh_ok)) begin
              state <= S_DECIDE;
            end
          end
        end
        S_DECIDE: begin
          batch_count <= d_bc;
          starve_count <= d_st;
          think_flag <= d_th;
          cnt <= '0;
          state <= S_LATTER;
        end
        S_LATTER: begin
          if (scan_end) begin
            n_ok <= rsel.dir ? {lat_ok, 1'b0} : {1'b0, lat_ok};
            n_idx[rsel.dir] <= lat_idx;
            prev_pick_time <= q.now;
            valid[r_idx] <= 1'b0;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    pidx <= cnt[dsch_pkg::IDX_W-1:0];
    if (state == S_IDLE && req.valid) begin
      q.cmd <= req.cmd;
      q.dir <= req.dir;
      q.sector <= req.sector;
      q.key <= req.sector + {{(dsch_pkg::SEC_W-16){1'b0}}, req.length};
      q.req_id <= req.req_id;
      q.now <= req.now;
      q.merge_ok <= req.merge_ok;
      rh_ok <= 1'b0;
      wh_ok <= 1'b0;
      hit_ok <= 1'b0;
      free_ok <= 1'b0;
      res_status <= dsch_pkg::ST_OK;
      res_id <= '0;
      res_dir <= 1'b0;
      res_sector <= '0;
    end
    if (state == S_DECIDE) begin
      rsel <= d_r;
      r_idx <= d_idx;
      lat_ok <= 1'b0;
    end
    if (state == S_SCAN && pv) begin
      if (q.cmd == dsch_pkg::CMD_ADD && !valid[pidx] && !free_ok) begin
        free_ok <= 1'b1;
        free_idx <= pidx;
      end
      if (q.cmd == dsch_pkg::CMD_MERGE && cand_v && rd_data.dir == q.dir &&
          rd_data.sector == q.key && (!hit_ok || cmp.older_cb)) begin
        hit_ok <= 1'b1;
        hit_idx <= pidx;
        hit <= rd_data;
      end
      if (q.cmd == dsch_pkg::CMD_DISPATCH) begin
        if (cand_v && !rd_data.dir && (!rh_ok || cmp.older_cb)) begin
          rh_ok <= 1'b1;
          rh_idx <= pidx;
          rh <= rd_data;
        end
        if (cand_v && rd_data.dir && (!wh_ok || cmp.older_cb)) begin
          wh_ok <= 1'b1;
          wh_idx <= pidx;
          wh <= rd_data;
        end
        if (pidx == n_idx[0]) begin
          n_ent[0] <= rd_data;
        end
        if (pidx == n_idx[1]) begin
          n_ent[1] <= rd_data;
        end
      end
    end
    if (state == S_LATTER && pv && cand_v && pidx != r_idx && rd_data.dir == rsel.dir &&
        cmp.before_rc && (!lat_ok || cmp.before_cb)) begin
      lat_ok <= 1'b1;
      lat_idx <= pidx;
      lat <= rd_data;
    end
    if (state == S_SCAN && scan_end) begin
      if (q.cmd == dsch_pkg::CMD_ADD && !free_ok) begin
        res_status <= dsch_pkg::ST_FULL;
      end
      if (q.cmd == dsch_pkg::CMD_DISPATCH && !rh_ok && !wh_ok) begin
        res_status <= dsch_pkg::ST_EMPTY;
      end
      if (q.cmd == dsch_pkg::CMD_MERGE) begin
        if (we) begin
          res_id <= hit.id;
          res_dir <= hit.dir;
          res_sector <= q.sector;
        end else begin
          res_status <= dsch_pkg::ST_MISS;
        end
      end
    end
    if (state == S_LATTER && scan_end) begin
      res_id <= rsel.id;
      res_dir <= rsel.dir;
      res_sector <= rsel.sector;
    end
    if (state == S_DONE && (!rsp.valid || rsp.ready)) begin
      rsp.status <= res_status;
      rsp.out_id <= res_id;
      rsp.out_dir <= res_dir;
      rsp.out_sector <= res_sector;
      rsp.tight_flag <= tight;
      rsp.latency_average <= ema;
    end
  end

  logic pick_commit, add_commit, scanning;
  assign pick_commit = (state == S_LATTER) && scan_end;
  assign add_commit = (state == S_SCAN) && scan_end && (q.cmd == dsch_pkg::CMD_ADD) &&
                      free_ok;
  assign scanning = (state == S_SCAN) || (state == S_LATTER);

  `DSCH_ASSERT_NEXT(a_dispatch_clears, clk, rst, pick_commit, !valid[$past(r_idx)])
  `DSCH_ASSERT_NEXT(a_add_sets, clk, rst, add_commit, valid[$past(free_idx)])
  `DSCH_ASSERT_IMPL(a_scan_bound, clk, rst, scanning, cnt <= (dsch_pkg::IDX_W+1)'(dsch_pkg::DEPTH))

endmodule

>>> dv/dsch_checker.sv
`timescale 1ns / 100ps

module dsch_checker (
  input logic clk,
  input logic rst,
  dsch_req_if req,
  dsch_rsp_if rsp,
  dsch_cfg_if cfg,
  output int fail_count,
  output int waiting,
  output int checked
);

  localparam int NONE = dsch_pkg::DEPTH;

  typedef struct packed {
    logic [1:0] status;
    logic [dsch_pkg::ID_W-1:0] id;
    logic dir;
    logic [dsch_pkg::SEC_W-1:0] sector;
    logic tight;
    logic [31:0] avg;
  } outcome_t;

  outcome_t expected_outcomes[$];

  // Register copies.
  logic [15:0] rd_expire, wr_expire;
  logic [7:0] starve_lim, batch_lim, think_ticks, lat_window;
  logic merge_en;
  logic [31:0] lat_target;

  // Request table copy.
  logic v[dsch_pkg::DEPTH];
  logic d[dsch_pkg::DEPTH];
  logic [dsch_pkg::SEC_W-1:0] sec[dsch_pkg::DEPTH];
  logic [dsch_pkg::ID_W-1:0] rid[dsch_pkg::DEPTH];
  logic [31:0] dl[dsch_pkg::DEPTH];
  logic [31:0] ord[dsch_pkg::DEPTH];

  logic [31:0] arrivals;
  int nxt[2];
  int unsigned batch_n;
  logic [7:0] starve_n;
  logic [31:0] last_disp;
  logic think;
  logic [31:0] ema, win_max;
  int unsigned win_n;
  logic tight;

  function automatic bit is_older(int a, int b);
    logic [31:0] age_a, age_b;
    age_a = arrivals - ord[a];
    age_b = arrivals - ord[b];
    return age_a > age_b;
  endfunction

  function automatic bit sorts_ahead(int a, int b);
    if (sec[a] != sec[b]) return sec[a] < sec[b];
    return is_older(a, b);
  endfunction

  function automatic bit live(int i);
    return i < dsch_pkg::DEPTH && v[i];
  endfunction

  // True when a is later than b, with 32-bit wraparound.
  function automatic bit later32(logic [31:0] a, logic [31:0] b);
    logic [31:0] diff;
    diff = b - a;
    return diff[31];
  endfunction

  function automatic int oldest_of(logic dir);
    int best;
    best = NONE;
    for (int i = 0; i < dsch_pkg::DEPTH; i++)
      if (v[i] && d[i] == dir && (best == NONE || is_older(i, best))) best = i;
    return best;
  endfunction

  function automatic int next_higher(int r);
    int best;
    best = NONE;
    for (int i = 0; i < dsch_pkg::DEPTH; i++)
      if (i != r && v[i] && d[i] == d[r] && sorts_ahead(r, i) &&
          (best == NONE || sorts_ahead(i, best))) best = i;
    return best;
  endfunction

  function automatic outcome_t schedule_step(logic [1:0] cmd, logic dir,
                                             logic [dsch_pkg::SEC_W-1:0] sector,
                                             logic [15:0] len,
                                             logic [dsch_pkg::ID_W-1:0] id, logic [31:0] now,
                                             logic [31:0] lat, logic pass, logic mok);
    outcome_t o;
    int slot, rh, wh, r, head, hit;
    bit find, pick_read, below;
    logic ddir;
    logic [31:0] limit_t;
    logic [dsch_pkg::SEC_W-1:0] key;
    logic [32:0] gap;
    o = '0;
    case (cmd)
      dsch_pkg::CMD_ADD: begin
        slot = NONE;
        for (int i = 0; i < dsch_pkg::DEPTH; i++)
          if (!v[i] && slot == NONE) slot = i;
        if (slot == NONE) begin
          o.status = dsch_pkg::ST_FULL;
        end else begin
          v[slot] = 1'b1;
          d[slot] = dir;
          sec[slot] = sector;
          rid[slot] = id;
          dl[slot] = now + (dir ? {16'd0, wr_expire} : {16'd0, rd_expire});
          ord[slot] = arrivals;
          arrivals = arrivals + 32'd1;
        end
      end
      dsch_pkg::CMD_DISPATCH: begin
        rh = oldest_of(1'b0);
        wh = oldest_of(1'b1);
        find = 1'b1;
        ddir = 1'b0;
        if (rh == NONE && wh == NONE) begin
          o.status = dsch_pkg::ST_EMPTY;
        end else begin
          if (tight && batch_n != 0) batch_n = batch_lim;
          limit_t = last_disp + {24'd0, think_ticks};
          if (last_disp != 32'd0 && later32(now, limit_t)) begin
            think = 1'b1;
            starve_n = 8'd0;
          end
          r = live(nxt[1]) ? nxt[1] : nxt[0];
          if (live(r) && batch_n < batch_lim) begin
            find = 1'b0;
          end else if (rh == NONE) begin
            starve_n = 8'd0;
            ddir = 1'b1;
          end else begin
            pick_read = 1'b1;
            if (!think) begin
              below = starve_n < starve_lim;
              if (starve_n != 8'hff) starve_n = starve_n + 8'd1;
              pick_read = below || wh == NONE;
            end
            if (pick_read) begin
              think = 1'b0;
              ddir = 1'b0;
            end else begin
              starve_n = 8'd0;
              ddir = 1'b1;
            end
          end
          if (find) begin
            head = ddir ? wh : rh;
            if (later32(now, dl[head] - 32'd1) || !live(nxt[ddir])) r = head;
            else r = nxt[ddir];
            batch_n = 0;
          end
          batch_n++;
          nxt[0] = NONE;
          nxt[1] = NONE;
          nxt[d[r]] = next_higher(r);
          last_disp = now;
          v[r] = 1'b0;
          o.id = rid[r];
          o.dir = d[r];
          o.sector = sec[r];
        end
      end
      dsch_pkg::CMD_COMPLETE: begin
        if (!dir && !pass) begin
          if (lat > win_max) win_max = lat;
          if (ema == 32'd0) begin
            ema = lat;
          end else if (lat >= ema) begin
            ema = ema + ((lat - ema) >> 3);
          end else begin
            // Rounding up on the way down keeps the step a signed floor.
            gap = {1'b0, ema - lat} + 33'd7;
            ema = ema - {2'd0, gap[32:3]};
          end
          win_n++;
          if (win_n >= lat_window) begin
            tight = win_max > lat_target;
            win_max = '0;
            win_n = 0;
          end
        end
      end
      default: begin
        hit = NONE;
        o.status = dsch_pkg::ST_MISS;
        if (merge_en) begin
          key = sector + {{(dsch_pkg::SEC_W-16){1'b0}}, len};
          for (int i = 0; i < dsch_pkg::DEPTH; i++)
            if (v[i] && d[i] == dir && sec[i] == key && (hit == NONE || is_older(i, hit)))
              hit = i;
          if (hit != NONE && mok) begin
            sec[hit] = sector;
            o.status = dsch_pkg::ST_OK;
            o.id = rid[hit];
            o.dir = d[hit];
            o.sector = sector;
          end
        end
      end
    endcase
    o.tight = tight;
    o.avg = ema;
    return o;
  endfunction

  always @(posedge clk) begin
    outcome_t got, want;
    if (rst) begin
      rd_expire <= 16'd6;
      wr_expire <= 16'd30;
      starve_lim <= 8'd6;
      batch_lim <= 8'd6;
      merge_en <= 1'b1;
      think_ticks <= 8'd2;
      lat_target <= 32'd5000000;
      lat_window <= 8'd4;
      for (int i = 0; i < dsch_pkg::DEPTH; i++) v[i] = 1'b0;
      arrivals = '0;
      nxt[0] = NONE;
      nxt[1] = NONE;
      batch_n = 0;
      starve_n = 8'd0;
      last_disp = '0;
      think = 1'b0;
      ema = '0;
      win_max = '0;
      win_n = 0;
      tight = 1'b0;
      expected_outcomes.delete();
      fail_count <= 0;
      checked <= 0;
      waiting <= 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.addr)
          dsch_pkg::REG_READ_EXPIRE: rd_expire <= cfg.data[15:0];
          dsch_pkg::REG_WRITE_EXPIRE: wr_expire <= cfg.data[15:0];
          dsch_pkg::REG_STARVED_LIMIT: starve_lim <= cfg.data[7:0];
          dsch_pkg::REG_BATCH_LIMIT: batch_lim <= cfg.data[7:0];
          dsch_pkg::REG_FRONT_MERGE: merge_en <= cfg.data[0];
          dsch_pkg::REG_THINKTIME: think_ticks <= cfg.data[7:0];
          dsch_pkg::REG_LAT_TARGET: lat_target <= cfg.data;
          dsch_pkg::REG_LAT_WINDOW: lat_window <= cfg.data[7:0];
          default: ;
        endcase
      end
      if (req.valid && req.ready)
        expected_outcomes.push_back(schedule_step(req.cmd, req.dir, req.sector, req.length,
                                                  req.req_id, req.now, req.latency,
                                                  req.passthrough, req.merge_ok));
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.status, rsp.out_id, rsp.out_dir, rsp.out_sector, rsp.tight_flag,
                rsp.latency_average};
        checked <= checked + 1;
        if (expected_outcomes.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: response with none outstanding: %p", $realtime, got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_outcomes.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display("%0t: mismatch\n  expected %p\n  actual   %p", $realtime, want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
      waiting <= expected_outcomes.size();
    end
  end

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps

module tb;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic calm = 1'b0;
  int fail_count, waiting, checked;
  int cmd_count[4];
  int phases;
  logic [31:0] tick;
  logic [dsch_pkg::SEC_W:0] recent[$];

  dsch_req_if req_ch ();
  dsch_rsp_if rsp_ch ();
  dsch_cfg_if cfg_ch ();

  deadline_request_scheduler uut (
    .clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch), .cfg(cfg_ch)
  );

  dsch_checker chk (
    .clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch), .cfg(cfg_ch),
    .fail_count(fail_count), .waiting(waiting), .checked(checked)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk)
    rsp_ch.ready <= !rst && (calm || $urandom_range(0, 99) >= 13);

  task automatic send(logic [1:0] cmd, logic dir, logic [dsch_pkg::SEC_W-1:0] sector,
                      logic [15:0] len, logic [dsch_pkg::ID_W-1:0] id, logic [31:0] now,
                      logic [31:0] lat, logic pass, logic mok);
    if (!calm && $urandom_range(0, 99) < 13) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    req_ch.cmd <= cmd;
    req_ch.dir <= dir;
    req_ch.sector <= sector;
    req_ch.length <= len;
    req_ch.req_id <= id;
    req_ch.now <= now;
    req_ch.latency <= lat;
    req_ch.passthrough <= pass;
    req_ch.merge_ok <= mok;
    req_ch.valid <= 1'b1;
    cmd_count[cmd]++;
    if (cmd == dsch_pkg::CMD_ADD) begin
      recent.push_back({dir, sector});
      if (recent.size() > 64) void'(recent.pop_front());
    end
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Drops valid and waits until every outstanding transaction has answered.
  task automatic drain_all();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (waiting != 0);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    cfg_ch.addr <= addr;
    cfg_ch.data <= data;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic configure(logic [15:0] rd, logic [15:0] wr, logic [7:0] starve,
                           logic [7:0] batch, logic merge, logic [7:0] think,
                           logic [31:0] target, logic [7:0] window);
    write_reg(dsch_pkg::REG_READ_EXPIRE, {16'd0, rd});
    write_reg(dsch_pkg::REG_WRITE_EXPIRE, {16'd0, wr});
    write_reg(dsch_pkg::REG_STARVED_LIMIT, {24'd0, starve});
    write_reg(dsch_pkg::REG_BATCH_LIMIT, {24'd0, batch});
    write_reg(dsch_pkg::REG_FRONT_MERGE, {31'd0, merge});
    write_reg(dsch_pkg::REG_THINKTIME, {24'd0, think});
    write_reg(dsch_pkg::REG_LAT_TARGET, target);
    write_reg(dsch_pkg::REG_LAT_WINDOW, {24'd0, window});
    cfg_ch.valid <= 1'b0;
    phases++;
  endtask

  task automatic random_item(int mode);
    int pick;
    logic [dsch_pkg::SEC_W:0] ent;
    logic [dsch_pkg::SEC_W-1:0] sector;
    logic [15:0] len;
    logic [31:0] lat;
    pick = $urandom_range(0, 99);
    tick = ($urandom_range(0, 49) == 0) ? $urandom : tick + $urandom_range(0, 3);
    sector = ($urandom_range(0, 9) == 0) ? (dsch_pkg::SEC_W)'({$urandom, $urandom})
                                         : (dsch_pkg::SEC_W)'($urandom_range(0, 200));
    case ($urandom_range(0, 9))
      0: lat = $urandom;
      1: lat = 32'd0;
      default: lat = $urandom_range(0, 10000000);
    endcase
    // Fill phases push the table toward full, drain phases empty it.
    if (mode == 0) pick = (pick < 75) ? 0 : pick;
    else if (mode == 1) pick = (pick < 75) ? 40 : pick;
    if (pick < 35) begin
      send(dsch_pkg::CMD_ADD, 1'($urandom_range(0, 1)), sector, 16'($urandom),
           (dsch_pkg::ID_W)'($urandom), tick, $urandom,
           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end else if (pick < 70) begin
      send(dsch_pkg::CMD_DISPATCH, 1'($urandom_range(0, 1)), sector, 16'($urandom),
           (dsch_pkg::ID_W)'($urandom), tick, lat,
           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end else if (pick < 85) begin
      send(dsch_pkg::CMD_COMPLETE, $urandom_range(0, 4) == 0, sector, 16'($urandom),
           (dsch_pkg::ID_W)'($urandom), tick, lat,
           $urandom_range(0, 5) == 0, 1'($urandom_range(0, 1)));
    end else begin
      // Aim most lookups at a recently added start so that they can hit.
      len = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8));
      if (recent.size() != 0 && $urandom_range(0, 4) != 0) begin
        ent = recent[$urandom_range(0, recent.size() - 1)];
        send(dsch_pkg::CMD_MERGE, ent[dsch_pkg::SEC_W],
             ent[dsch_pkg::SEC_W-1:0] - {{(dsch_pkg::SEC_W-16){1'b0}}, len}, len,
             (dsch_pkg::ID_W)'($urandom), tick, lat,
             1'($urandom_range(0, 1)), $urandom_range(0, 4) != 0);
      end else begin
        send(dsch_pkg::CMD_MERGE, 1'($urandom_range(0, 1)), sector, len,
             (dsch_pkg::ID_W)'($urandom), tick, lat,
             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic random_run(int count);
    int mode;
    mode = 2;
    for (int n = 0; n < count; n++) begin
      if (n % 64 == 0) mode = $urandom_range(0, 3);
      random_item(mode);
    end
  endtask

  initial begin
    req_ch.valid <= 1'b0;
    req_ch.cmd <= dsch_pkg::CMD_ADD;
    req_ch.dir <= 1'b0;
    req_ch.sector <= '0;
    req_ch.length <= '0;
    req_ch.req_id <= '0;
    req_ch.now <= '0;
    req_ch.latency <= '0;
    req_ch.passthrough <= 1'b0;
    req_ch.merge_ok <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.addr <= dsch_pkg::REG_READ_EXPIRE;
    cfg_ch.data <= '0;
    tick = 32'd100;
    phases = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    configure(16'd6, 16'd30, 8'd6, 8'd6, 1'b1, 8'd2, 32'd5000000, 8'd4);
    // Directed: field extremes, the idle check skipped at time zero, wrapped merge keys,
    // equal sectors, ignored completions and an empty table.
    send(dsch_pkg::CMD_DISPATCH, 1'b0, '0, '0, '0, 32'd0, '0, 1'b0, 1'b0);
    send(dsch_pkg::CMD_ADD, 1'b0, '0, 16'hffff, '0, 32'd0, '0, 1'b0, 1'b0);
    send(dsch_pkg::CMD_ADD, 1'b1, '1, 16'd0, '1, 32'hffffffff, '1, 1'b1, 1'b1);
    send(dsch_pkg::CMD_ADD, 1'b0, 48'd7, 16'd0, 16'd5, 32'd1, '0, 1'b0, 1'b0);
    send(dsch_pkg::CMD_ADD, 1'b0, 48'd7, 16'd0, 16'd6, 32'd1, '0, 1'b0, 1'b0);
    send(dsch_pkg::CMD_MERGE, 1'b0, '1, 16'd1, '0, 32'd2, '0, 1'b0, 1'b1);
    send(dsch_pkg::CMD_MERGE, 1'b0, 48'd3, 16'd4, '0, 32'd2, '0, 1'b0, 1'b1);
    send(dsch_pkg::CMD_MERGE, 1'b0, 48'd2, 16'd5, '0, 32'd2, '0, 1'b0, 1'b0);
    send(dsch_pkg::CMD_MERGE, 1'b1, 48'd0, 16'd9, '0, 32'd2, '0, 1'b0, 1'b1);
    send(dsch_pkg::CMD_DISPATCH, 1'b0, '0, '0, '0, 32'd0, '0, 1'b0, 1'b0);
    send(dsch_pkg::CMD_DISPATCH, 1'b0, '0, '0, '0, 32'd40, '0, 1'b0, 1'b0);
    send(dsch_pkg::CMD_COMPLETE, 1'b1, '0, '0, '0, 32'd41, 32'd9000000, 1'b0, 1'b0);
    send(dsch_pkg::CMD_COMPLETE, 1'b0, '0, '0, '0, 32'd41, 32'd9000000, 1'b1, 1'b0);
    send(dsch_pkg::CMD_COMPLETE, 1'b0, '0, '0, '0, 32'd41, 32'd0, 1'b0, 1'b0);
    send(dsch_pkg::CMD_COMPLETE, 1'b0, '0, '0, '0, 32'd41, 32'hffffffff, 1'b0, 1'b0);
    send(dsch_pkg::CMD_COMPLETE, 1'b0, '0, '0, '0, 32'd41, 32'd1000, 1'b0, 1'b0);
    send(dsch_pkg::CMD_COMPLETE, 1'b0, '0, '0, '0, 32'd41, 32'd6000000, 1'b0, 1'b0);
    send(dsch_pkg::CMD_DISPATCH, 1'b0, '0, '0, '0, 32'd42, '0, 1'b0, 1'b0);
    send(dsch_pkg::CMD_DISPATCH, 1'b0, '0, '0, '0, 32'hffffffff, '0, 1'b0, 1'b0);
    send(dsch_pkg::CMD_DISPATCH, 1'b0, '0, '0, '0, 32'd50, '0, 1'b0, 1'b0);
    send(dsch_pkg::CMD_DISPATCH, 1'b0, '0, '0, '0, 32'd51, '0, 1'b0, 1'b0);
    send(dsch_pkg::CMD_DISPATCH, 1'b0, '0, '0, '0, 32'd52, '0, 1'b0, 1'b0);
    random_run(200);
    drain_all();

    configure(16'd0, 16'd0, 8'd0, 8'd0, 1'b1, 8'd0, 32'd0, 8'd1);
    random_run(120);
    drain_all();
    random_run(120);
    drain_all();

    configure(16'hffff, 16'hffff, 8'hff, 8'hff, 1'b0, 8'hff, 32'hffffffff, 8'hff);
    calm = 1'b1;
    random_run(150);
    calm = 1'b0;
    random_run(100);
    drain_all();

    configure(16'($urandom_range(0, 40)), 16'($urandom_range(0, 80)),
              8'($urandom_range(1, 8)), 8'($urandom_range(1, 16)), 1'b1,
              8'($urandom_range(0, 5)), $urandom_range(500000, 8000000), 8'd0);
    random_run(230);
    drain_all();

    configure(16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom), 1'b1,
              8'($urandom), $urandom_range(0, 12000000), 8'($urandom_range(1, 255)));
    random_run(210);
    drain_all();

    $display("Covered %0d adds, %0d dispatches, %0d completions and %0d front merges",
             cmd_count[dsch_pkg::CMD_ADD], cmd_count[dsch_pkg::CMD_DISPATCH],
             cmd_count[dsch_pkg::CMD_COMPLETE], cmd_count[dsch_pkg::CMD_MERGE]);
    $display("over %0d register settings; %0d responses were compared.", phases, checked);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #60000000;
    $display("status: fail");
    $finish;
  end

endmodule
